[rtl/etfl_pkg.sv]
// Shared constants, types and the control store of the entry table free list.
package etfl_pkg;

  localparam int unsigned TABLE_DEPTH       = 1024;
  localparam int unsigned ENTRIES_PER_BLOCK = 16;
  localparam int unsigned IDX_W             = 10;
  localparam int unsigned CNT_W             = 11;
  localparam int unsigned MAXR_W            = 11;
  localparam int unsigned PADDR_W           = 3;

  localparam logic [1:0] OP_INIT  = 2'd0;
  localparam logic [1:0] OP_ALLOC = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;
  localparam logic [1:0] ST_ZERO  = 2'd3;

  localparam logic REG_MAX_ENTRIES = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_INIT_END,
    S_ALLOC,
    S_FREE,
    S_NOP
  } step_e;

  typedef enum logic [1:0] {
    C_DISPATCH,
    C_WALK,
    C_EMIT
  } cond_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_WALK,
    ACT_INIT_END,
    ACT_ALLOC,
    ACT_FREE
  } act_e;

  typedef struct packed {
    cond_e cond;
    act_e  act;
    logic  walk_clr;
    step_e nxt;
  } ucode_t;

  // Control store: one word per step.
  function automatic ucode_t ucode_rom(step_e s);
    ucode_t w;
    unique case (s)
      S_IDLE:     w = '{cond: C_DISPATCH, act: ACT_NONE,     walk_clr: 1'b1, nxt: S_IDLE};
      S_INIT:     w = '{cond: C_WALK,     act: ACT_WALK,     walk_clr: 1'b0, nxt: S_INIT_END};
      S_INIT_END: w = '{cond: C_EMIT,     act: ACT_INIT_END, walk_clr: 1'b0, nxt: S_IDLE};
      S_ALLOC:    w = '{cond: C_EMIT,     act: ACT_ALLOC,    walk_clr: 1'b0, nxt: S_IDLE};
      S_FREE:     w = '{cond: C_EMIT,     act: ACT_FREE,     walk_clr: 1'b0, nxt: S_IDLE};
      S_NOP:      w = '{cond: C_EMIT,     act: ACT_NONE,     walk_clr: 1'b0, nxt: S_IDLE};
      default:    w = '{cond: C_DISPATCH, act: ACT_NONE,     walk_clr: 1'b1, nxt: S_IDLE};
    endcase
    return w;
  endfunction

  // Dispatch table: first step of each operation.
  function automatic step_e dispatch(logic [1:0] op);
    step_e s;
    unique case (op)
      OP_INIT:  s = S_INIT;
      OP_ALLOC: s = S_ALLOC;
      OP_FREE:  s = S_FREE;
      default:  s = S_NOP;
    endcase
    return s;
  endfunction

endpackage

[rtl/etfl_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module etfl_ram #(
  parameter int unsigned WIDTH = 10,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/entry_table_free_list.sv]
// Top level of the entry table free list: sequencer, datapath and config port.
// Allocate, free and the unused opcode pass from the idle step to a result step,
// which loads the result register once the output register is free; no new item is
// taken until that step is done. Init writes one link per cycle, then loads its result.
// Reset clears the step counter, head, free count and output valid, and sets
// max_entries to 1024; the link memory is not cleared and holds nothing valid until init.
module entry_table_free_list import etfl_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input channel.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          op_i,
  input  logic [IDX_W-1:0]    index_i,
  // Result channel.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          status_o,
  output logic [IDX_W-1:0]    entry_o,
  output logic [CNT_W-1:0]    free_left_o,
  // Configuration port.
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  // Sequencer state.
  step_e            step_q, step_d;
  ucode_t           cw;

  // Datapath registers.
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [CNT_W-1:0]  walk_q, walk_d;
  logic [MAXR_W-1:0] max_q;
  logic [IDX_W-1:0]  idx_q;

  // Output register.
  logic              out_valid_q;
  logic [1:0]        status_q;
  logic [IDX_W-1:0]  entry_q;
  logic [CNT_W-1:0]  free_left_q;

  // Result of the current step.
  logic [1:0]        res_status;
  logic [IDX_W-1:0]  res_entry;

  // Link memory port.
  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [IDX_W-1:0]  ram_wdata;
  logic [IDX_W-1:0]  ram_rdata;

  logic              accept;
  logic              out_free;
  logic              commit;
  logic              walk_live;
  logic              cfg_wr;
  logic [MAXR_W:0]   round_up;
  logic [MAXR_W:0]   round_al;
  logic [CNT_W-1:0]  cap;
  logic [CNT_W-1:0]  walk_nxt;

  // The configuration port never waits; a write completes in its access cycle.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;
  assign prdata = (paddr[PADDR_W-1] == REG_MAX_ENTRIES) ? {{(32-MAXR_W){1'b0}}, max_q} : '0;

  // Capacity is the request rounded up to a whole block, limited to the table depth.
  assign round_up = {1'b0, max_q} + (MAXR_W+1)'(ENTRIES_PER_BLOCK - 1);
  assign round_al = round_up & ~((MAXR_W+1)'(ENTRIES_PER_BLOCK - 1));
  assign cap      = (round_al > (MAXR_W+1)'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                          : round_al[CNT_W-1:0];

  // The control word of the current step drives everything below.
  assign cw = ucode_rom(step_q);

  // Items are taken only while the sequencer sits in its idle step. A result
  // that still waits in the output register does not hold up the next transfer.
  assign in_stall_o = (step_q != S_IDLE);
  assign accept     = in_valid_i & (step_q == S_IDLE);

  // A result step finishes only when the output register can take its result;
  // every state update of such a step waits for that, so a stall repeats nothing.
  assign out_free  = ~out_valid_q | ~out_stall_i;
  assign commit    = (cw.cond == C_EMIT) & out_free;
  assign walk_live = (walk_q < cap);
  assign walk_nxt  = walk_q + CNT_W'(1);

  // Step counter with its conditional jumps.
  always_comb begin
    unique case (cw.cond)
      C_DISPATCH: step_d = in_valid_i ? dispatch(op_i) : step_q;
      C_WALK:     step_d = walk_live ? step_q : cw.nxt;
      C_EMIT:     step_d = out_free ? cw.nxt : step_q;
      default:    step_d = S_IDLE;
    endcase
  end

  // Datapath.
  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    walk_d     = walk_q;
    res_status = ST_OK;
    res_entry  = '0;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = head_q;
    if (cw.walk_clr) begin
      walk_d = '0;
    end
    unique case (cw.act)
      ACT_NONE: begin
      end
      ACT_WALK: begin
        // Each entry links to the next one; the last links to itself.
        if (walk_live) begin
          ram_we    = 1'b1;
          ram_waddr = walk_q[IDX_W-1:0];
          ram_wdata = (walk_nxt < cap) ? walk_nxt[IDX_W-1:0] : walk_q[IDX_W-1:0];
          walk_d    = walk_nxt;
        end
      end
      ACT_INIT_END: begin
        if (commit) begin
          head_d  = '0;
          count_d = cap;
        end
      end
      ACT_ALLOC: begin
        // The link of the head was read during the idle step and is ready now.
        if (count_q == '0) begin
          res_status = ST_FULL;
        end else begin
          res_entry = head_q;
          if (commit) begin
            head_d  = ram_rdata;
            count_d = count_q - CNT_W'(1);
          end
        end
      end
      ACT_FREE: begin
        // Entry zero is checked before the range; double frees push again and
        // the count saturates at the capacity.
        if (idx_q == '0) begin
          res_status = ST_ZERO;
        end else if ({1'b0, idx_q} >= cap) begin
          res_status = ST_RANGE;
        end else if (commit) begin
          ram_we = 1'b1;
          head_d = idx_q;
          if (count_q < cap) begin
            count_d = count_q + CNT_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // The link of the current head is read every cycle, so an allocate finds it
  // waiting in its allocate step.
  etfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (TABLE_DEPTH)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      walk_q      <= '0;
      max_q       <= MAXR_W'(TABLE_DEPTH);
      out_valid_q <= 1'b0;
    end else begin
      step_q  <= step_d;
      head_q  <= head_d;
      count_q <= count_d;
      walk_q  <= walk_d;
      if (cfg_wr && (paddr[PADDR_W-1] == REG_MAX_ENTRIES)) begin
        max_q <= pwdata[MAXR_W-1:0];
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      idx_q <= index_i;
    end
    if (commit) begin
      status_q    <= res_status;
      entry_q     <= res_entry;
      free_left_q <= count_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign entry_o     = entry_q;
  assign free_left_o = free_left_q;

`ifndef SYNTHESIS
  // The free count never exceeds the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("free count above table depth");

  // Only the init walk and a free write the link memory.
  a_ram_we_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (step_q == S_INIT || step_q == S_FREE))
    else $error("link write outside init or free");

  // A completed allocate takes exactly one entry off the count.
  a_alloc_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q == S_ALLOC && out_free && count_q != '0) |=>
      (count_q == $past(count_q) - CNT_W'(1)))
    else $error("allocate did not decrement the free count");

  // A nonzero entry in a result only comes with a good status.
  a_entry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && entry_o != '0) |-> (status_o == ST_OK))
    else $error("entry reported with an error status");
`endif

endmodule
